### rtl/core/working_set_fault_tracker_assert.svh
// assertion macros for the working set fault tracker checker
// depends on nothing; included by the checker file
`ifndef WORKING_SET_FAULT_TRACKER_ASSERT_SVH
`define WORKING_SET_FAULT_TRACKER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define WSFT_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define WSFT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/wsft_pkg.sv
// shared constants and types of the working set fault tracker
// depends on nothing; imported by every module of the block but the ram
package wsft_pkg;

   localparam int MAX_WINDOW = 256;
   localparam int PAGE_COUNT = 256;

   localparam int PAGE_W = 8;
   localparam int WIN_W  = 9;
   localparam int SIZE_W = 9;
   localparam int FTOT_W = 32;
   localparam int STOT_W = 40;

   localparam int RING_AW = $clog2(MAX_WINDOW);
   localparam int PAGE_AW = $clog2(PAGE_COUNT);
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);

   localparam int REQ_DATA_W = ((PAGE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 1 + SIZE_W + FTOT_W + STOT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic               en;
      logic [PAGE_AW-1:0] addr;
      logic [CNT_W-1:0]   data;
   } cnt_wr_type;

   typedef struct packed {
      logic [STOT_W-1:0] size_total;
      logic [FTOT_W-1:0] fault_total;
      logic [SIZE_W-1:0] set_size;
      logic              fault;
   } rsp_item_type;

endpackage

### rtl/core/working_set_fault_tracker.sv
// working set fault tracker: history ring ram, count table, result buffer
// a transaction passes stages s1, s2 and s3; s3 pushes the result into the buffer
// no new transaction is taken while one is in s1, as the count table's single read
//   and write port does two read-modify-writes per page reference
// reset (synchronous): window 1, ring empty, counts cleared at once by valid bits
module working_set_fault_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wsft_pkg::REQ_DATA_W-1:0]  req_tdata,   // page[7:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wsft_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // fault, set_size, fault_total,
                                                         // size_total, zero fill
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wsft_pkg::WIN_W-1:0]       csr_data     // window_size
);
   import wsft_pkg::*;

   localparam logic [CNT_W:0] MAX_EXT = (CNT_W+1)'(MAX_WINDOW);

   logic [CNT_W-1:0]   win_ff, win_in;
   logic [RING_AW-1:0] ring_ptr_ff, ring_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   distinct_ff, distinct_in;
   logic [FTOT_W-1:0]  fault_sum_ff, fault_sum_in;
   logic [STOT_W-1:0]  size_sum_ff, size_sum_in;

   logic               s1_vld_ff, s1_vld_in;
   logic               s2_vld_ff, s2_vld_in;
   logic               s3_vld_ff, s3_vld_in;
   logic               s1_drop_ff, s1_drop_in;
   logic               s2_drop_ff, s2_drop_in;
   logic [PAGE_AW-1:0] s1_page_ff, s1_page_in;
   logic [PAGE_AW-1:0] s2_page_ff, s2_page_in;
   logic [PAGE_AW-1:0] s3_page_ff, s3_page_in;
   logic [PAGE_AW-1:0] s2_old_ff, s2_old_in;

   logic               req_acc, csr_acc;
   logic [PAGE_AW-1:0] page_idx;
   logic [CNT_W:0]     ptr_ext, win_ext;
   logic [RING_AW-1:0] old_idx;
   logic               drop_now;
   logic [PAGE_AW-1:0] ring_rd_data;
   logic [CNT_W-1:0]   win_eff;

   logic [PAGE_AW-1:0] cnt_rd_addr;
   logic [CNT_W-1:0]   cnt_rd;
   cnt_wr_type         cnt_wr;

   logic               fault_now;
   logic [CNT_W-1:0]   dist_inc;
   logic [STOT_W:0]    size_add;
   rsp_item_type       push_item, head_item;
   logic [FIFO_AW:0]   fifo_count;
   logic [FIFO_AW:0]   occupancy;

   // a pending window write goes first and takes the block while it is idle
   assign occupancy  = fifo_count + (FIFO_AW+1)'(s2_vld_ff) + (FIFO_AW+1)'(s3_vld_ff);
   assign req_tready = !s1_vld_ff && !csr_valid &&
                       (occupancy < (FIFO_AW+1)'(FIFO_DEPTH));
   assign csr_ready  = !(s1_vld_ff || s2_vld_ff || s3_vld_ff);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   assign page_idx = PAGE_AW'(req_tdata[PAGE_W-1:0] % PAGE_COUNT);
   assign ptr_ext  = (CNT_W+1)'(ring_ptr_ff);
   assign win_ext  = (CNT_W+1)'(win_ff);
   assign old_idx  = (ptr_ext >= win_ext) ? RING_AW'(ptr_ext - win_ext)
                                          : RING_AW'(ptr_ext + MAX_EXT - win_ext);
   assign drop_now = (fill_ff >= win_ff);

   assign win_eff = (csr_data == '0) ? CNT_W'(1) :
                    (int'(csr_data) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(csr_data);

   // history ring: write the new page, read the page leaving the window
   wsft_ram #(.WIDTH(PAGE_AW), .DEPTH(MAX_WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (ring_ptr_ff),
      .wr_data (page_idx),
      .rd_addr (old_idx),
      .rd_data (ring_rd_data)
   );

   // outgoing page read in stage 1, incoming page read in stage 2
   assign cnt_rd_addr = s1_vld_ff ? ring_rd_data : s2_page_ff;

   always_comb begin
      if (s3_vld_ff) begin
         cnt_wr.en   = 1'b1;
         cnt_wr.addr = s3_page_ff;
         cnt_wr.data = cnt_rd + 1'b1;
      end else begin
         cnt_wr.en   = s2_vld_ff && s2_drop_ff && (cnt_rd != '0);
         cnt_wr.addr = s2_old_ff;
         cnt_wr.data = cnt_rd - 1'b1;
      end
   end

   wsft_count_table u_counts (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_acc),
      .rd_addr  (cnt_rd_addr),
      .wr       (cnt_wr),
      .rd_count (cnt_rd)
   );

   assign fault_now = (cnt_rd == '0);
   assign dist_inc  = distinct_ff + CNT_W'(fault_now);
   assign size_add  = (STOT_W+1)'(size_sum_ff) + (STOT_W+1)'(dist_inc);

   always_comb begin
      win_in       = csr_acc ? win_eff : win_ff;
      ring_ptr_in  = ring_ptr_ff;
      fill_in      = fill_ff;
      distinct_in  = distinct_ff;
      fault_sum_in = fault_sum_ff;
      size_sum_in  = size_sum_ff;

      if (req_acc) begin
         ring_ptr_in = (ring_ptr_ff == RING_AW'(MAX_WINDOW - 1)) ? '0 : ring_ptr_ff + 1'b1;
         fill_in     = drop_now ? win_ff : fill_ff + 1'b1;
      end

      if (s2_vld_ff && s2_drop_ff && (cnt_rd == CNT_W'(1)) && (distinct_ff != '0)) begin
         distinct_in = distinct_ff - 1'b1;
      end

      if (s3_vld_ff) begin
         distinct_in = dist_inc;
         if (fault_now && (fault_sum_ff != '1)) begin
            fault_sum_in = fault_sum_ff + 1'b1;
         end
         size_sum_in = size_add[STOT_W] ? '1 : size_add[STOT_W-1:0];
      end

      if (csr_acc) begin
         ring_ptr_in = '0;
         fill_in     = '0;
         distinct_in = '0;
      end

      s1_vld_in  = req_acc;
      s2_vld_in  = s1_vld_ff;
      s3_vld_in  = s2_vld_ff;
      s1_drop_in = drop_now;
      s2_drop_in = s1_drop_ff;
      s1_page_in = page_idx;
      s2_page_in = s1_page_ff;
      s3_page_in = s2_page_ff;
      s2_old_in  = ring_rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= CNT_W'(1);
         ring_ptr_ff  <= '0;
         fill_ff      <= '0;
         distinct_ff  <= '0;
         fault_sum_ff <= '0;
         size_sum_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
      end else begin
         win_ff       <= win_in;
         ring_ptr_ff  <= ring_ptr_in;
         fill_ff      <= fill_in;
         distinct_ff  <= distinct_in;
         fault_sum_ff <= fault_sum_in;
         size_sum_ff  <= size_sum_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
      end
      s1_drop_ff <= s1_drop_in;
      s2_drop_ff <= s2_drop_in;
      s1_page_ff <= s1_page_in;
      s2_page_ff <= s2_page_in;
      s3_page_ff <= s3_page_in;
      s2_old_ff  <= s2_old_in;
   end

   always_comb begin
      push_item.fault       = fault_now;
      push_item.set_size    = SIZE_W'(dist_inc);
      push_item.fault_total = fault_sum_in;
      push_item.size_total  = size_sum_in;
   end

   wsft_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_vld_ff),
      .push_item (push_item),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (head_item),
      .count     (fifo_count)
   );

   assign rsp_tdata = RSP_DATA_W'(head_item);

endmodule

### rtl/core/wsft_ram.sv
// generic single write port ram with one registered read port, read-first
// depends on nothing
module wsft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/wsft_count_table.sv
// per-page occurrence count table: ram, per-entry valid bits, write forwarding
// depends on wsft_pkg and wsft_ram
module wsft_count_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [wsft_pkg::PAGE_AW-1:0] rd_addr,
   input  wsft_pkg::cnt_wr_type        wr,
   output logic [wsft_pkg::CNT_W-1:0]  rd_count
);
   import wsft_pkg::*;

   logic [PAGE_COUNT-1:0] valid_ff, valid_in;
   logic                  fwd_hit_ff, fwd_hit_in;
   logic [CNT_W-1:0]      fwd_data_ff, fwd_data_in;
   logic                  entry_vld_ff, entry_vld_in;
   logic [CNT_W-1:0]      ram_rd_data;

   wsft_ram #(.WIDTH(CNT_W), .DEPTH(PAGE_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      fwd_hit_in   = wr.en && (wr.addr == rd_addr);
      fwd_data_in  = wr.data;
      entry_vld_in = valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      fwd_hit_ff   <= fwd_hit_in;
      fwd_data_ff  <= fwd_data_in;
      entry_vld_ff <= entry_vld_in;
   end

   // same-edge write wins, never-written entries read as zero
   assign rd_count = fwd_hit_ff   ? fwd_data_ff :
                     entry_vld_ff ? ram_rd_data : '0;

endmodule

### rtl/core/wsft_rsp_fifo.sv
// small result buffer between the update pipeline and the result channel
// depends on wsft_pkg
module wsft_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  wsft_pkg::rsp_item_type      push_item,
   input  logic                        pop_ready,
   output logic                        out_valid,
   output wsft_pkg::rsp_item_type      out_item,
   output logic [wsft_pkg::FIFO_AW:0]  count
);
   import wsft_pkg::*;

   rsp_item_type       entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/wsft_checker.sv
// port-level checker for the working set fault tracker, bound to the top level
// depends on wsft_pkg and working_set_fault_tracker_assert.svh
`include "working_set_fault_tracker_assert.svh"

module wsft_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wsft_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import wsft_pkg::*;

   // a stalled result holds its value
   `WSFT_ASSERT_CLK(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result changed while stalled")

   // no transaction right after another
   `WSFT_ASSERT_CLK(a_req_spacing, (req_tvalid && req_tready) |=> !req_tready, "request taken on consecutive cycles")

   // the current page is always in the working set
   `WSFT_ASSERT_CLK(a_size_nonzero, rsp_tvalid |-> (rsp_tdata[SIZE_W:1] != '0), "working set size of zero")

   // nothing to deliver right after reset
   `WSFT_ASSERT_ALWAYS(a_reset_empty, $fell(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

bind working_set_fault_tracker wsft_checker u_wsft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
